@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the UART framer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk_i while rst_ni is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/utf_pkg.sv @@
// ----------------------------------------------------------------------------
// utf_pkg
// Shared types and constants for the UART transmit framer.
// ----------------------------------------------------------------------------
package utf_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_EXTRA_DATA_BITS = 3'd0,
    REG_PARITY_MODE     = 3'd1,
    REG_TWO_STOP_BITS   = 3'd2,
    REG_INVERTED_LINE   = 3'd3,
    REG_BIT_PERIOD      = 3'd4
  } cfg_reg_e;

  // Parity mode codes. Any nonzero code other than odd gives even parity.
  localparam logic [1:0] PAR_NONE = 2'd0;
  localparam logic [1:0] PAR_ODD  = 2'd1;

  localparam logic [1:0]  RST_EXTRA_DATA_BITS = 2'd3;
  localparam logic [15:0] RST_BIT_PERIOD      = 16'd1667;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_PARITY = 2'd2,
    KIND_STOP   = 2'd3
  } slot_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DATA,
    ST_PARITY,
    ST_STOP,
    ST_LAST
  } back_state_e;

  // Frame format registers seen by the front end.
  typedef struct packed {
    logic [1:0] extra_data_bits;
    logic [1:0] parity_mode;
    logic       two_stop_bits;
    logic       inverted_line;
  } cfg_t;

  // One classified frame, handed from the front end to the serializer.
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] last_idx;
    logic       par_en;
    logic       par_val;
    logic       two_stop;
    logic       inv;
  } frame_t;

  // Frame queue depth.
  localparam int QAW    = 1;
  localparam int QDEPTH = 2 ** QAW;

endpackage

@@ hw/rtl/utf_front.sv @@
// ----------------------------------------------------------------------------
// utf_front
// Accepts bytes and turns each into a frame descriptor for the queue.
// ----------------------------------------------------------------------------
module utf_front (
  input  logic              push,
  input  logic [7:0]        data_byte_i,
  input  utf_pkg::cfg_t     cfg_i,
  input  logic              q_full_i,
  output logic              full,
  output logic              q_push_o,
  output utf_pkg::frame_t   q_frame_o
);

  logic [7:0] mask;
  logic [7:0] masked;

  // Keep only the low 5 + extra_data_bits bits of the byte.
  assign mask   = 8'hFF >> (2'd3 - cfg_i.extra_data_bits);
  assign masked = data_byte_i & mask;

  assign full     = q_full_i;
  assign q_push_o = push && !q_full_i;

  always_comb begin
    q_frame_o.data     = masked;
    q_frame_o.last_idx = {1'b0, cfg_i.extra_data_bits} + 3'd4;
    q_frame_o.par_en   = (cfg_i.parity_mode != utf_pkg::PAR_NONE);
    q_frame_o.par_val  = (^masked) ^ (cfg_i.parity_mode == utf_pkg::PAR_ODD);
    q_frame_o.two_stop = cfg_i.two_stop_bits;
    q_frame_o.inv      = cfg_i.inverted_line;
  end

endmodule

@@ hw/rtl/utf_fifo.sv @@
// ----------------------------------------------------------------------------
// utf_fifo
// Small frame queue between the front end and the serializer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  utf_pkg::frame_t wr_frame_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            valid_o,
  output utf_pkg::frame_t rd_frame_o
);

  utf_pkg::frame_t            mem_q [utf_pkg::QDEPTH];
  logic [utf_pkg::QAW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [utf_pkg::QAW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [utf_pkg::QAW:0]      cnt_q, cnt_d;
  logic                       do_wr;
  logic                       do_rd;

  assign full_o     = (cnt_q == (utf_pkg::QAW+1)'(utf_pkg::QDEPTH));
  assign valid_o    = (cnt_q != '0);
  assign rd_frame_o = mem_q[rd_ptr_q];
  assign do_wr      = wr_i && !full_o;
  assign do_rd      = rd_i && valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_frame_i;
    end
  end

  `ASSERT_CLK(a_cnt_bound, cnt_q <= (utf_pkg::QAW+1)'(utf_pkg::QDEPTH), "queue count over depth")
  `ASSERT_CLK(a_ptr_gap, (wr_ptr_q == rd_ptr_q) == ((cnt_q == '0) || full_o), "queue pointers out of step")

endmodule

@@ hw/rtl/utf_back.sv @@
// ----------------------------------------------------------------------------
// utf_back
// Serializer: walks one frame slot by slot into an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     bit_period_i,
  input  logic            q_valid_i,
  input  utf_pkg::frame_t q_frame_i,
  output logic            q_rd_o,
  output logic            empty,
  input  logic            pop,
  output logic            line_level_o,
  output logic [1:0]      slot_kind_o,
  output logic            last_slot_o
);

  utf_pkg::back_state_e st_q, st_d;
  utf_pkg::frame_t      cur_q, cur_d;
  logic [2:0]           idx_q, idx_d;
  logic [15:0]          tmr_q, tmr_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_level_q, out_level_d;
  utf_pkg::slot_kind_e  out_kind_q, out_kind_d;
  logic                 out_last_q, out_last_d;

  logic                 slot_active;
  logic                 emit;
  logic                 slot_level;
  utf_pkg::slot_kind_e  slot_kind;
  logic                 slot_last;

  // Next state.
  always_comb begin
    st_d  = st_q;
    idx_d = idx_q;
    unique case (st_q)
      utf_pkg::ST_IDLE: begin
        if (q_valid_i) st_d = utf_pkg::ST_START;
      end
      utf_pkg::ST_START: begin
        if (emit) begin
          st_d  = utf_pkg::ST_DATA;
          idx_d = 3'd0;
        end
      end
      utf_pkg::ST_DATA: begin
        if (emit) begin
          if (idx_q == cur_q.last_idx) begin
            if (cur_q.par_en) begin
              st_d = utf_pkg::ST_PARITY;
            end else if (cur_q.two_stop) begin
              st_d = utf_pkg::ST_STOP;
            end else begin
              st_d = utf_pkg::ST_LAST;
            end
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      utf_pkg::ST_PARITY: begin
        if (emit) st_d = cur_q.two_stop ? utf_pkg::ST_STOP : utf_pkg::ST_LAST;
      end
      utf_pkg::ST_STOP: begin
        if (emit) st_d = utf_pkg::ST_LAST;
      end
      utf_pkg::ST_LAST: begin
        if (emit) st_d = q_valid_i ? utf_pkg::ST_START : utf_pkg::ST_IDLE;
      end
      default: st_d = utf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine: slot contents, emit and queue read.
  always_comb begin
    slot_active = 1'b1;
    slot_level  = ~cur_q.inv;
    slot_kind   = utf_pkg::KIND_STOP;
    slot_last   = 1'b0;
    q_rd_o      = 1'b0;
    unique case (st_q)
      utf_pkg::ST_IDLE: begin
        slot_active = 1'b0;
        q_rd_o      = q_valid_i;
      end
      utf_pkg::ST_START: begin
        slot_level = cur_q.inv;
        slot_kind  = utf_pkg::KIND_START;
      end
      utf_pkg::ST_DATA: begin
        slot_level = cur_q.data[idx_q] ^ cur_q.inv;
        slot_kind  = utf_pkg::KIND_DATA;
      end
      utf_pkg::ST_PARITY: begin
        slot_level = cur_q.par_val ^ cur_q.inv;
        slot_kind  = utf_pkg::KIND_PARITY;
      end
      utf_pkg::ST_STOP: begin
        slot_kind = utf_pkg::KIND_STOP;
      end
      utf_pkg::ST_LAST: begin
        slot_last = 1'b1;
      end
      default: slot_active = 1'b0;
    endcase
    emit = slot_active && (!out_valid_q || pop) && (tmr_q == '0);
    if ((st_q == utf_pkg::ST_LAST) && emit) begin
      q_rd_o = q_valid_i;
    end
  end

  always_comb begin
    cur_d = q_rd_o ? q_frame_i : cur_q;
    if (emit) begin
      tmr_d = (bit_period_i > 16'd1) ? bit_period_i - 16'd1 : '0;
    end else begin
      tmr_d = (tmr_q != '0) ? tmr_q - 16'd1 : '0;
    end
    out_valid_d = out_valid_q && !pop;
    out_level_d = out_level_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_level_d = slot_level;
      out_kind_d  = slot_kind;
      out_last_d  = slot_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= utf_pkg::ST_IDLE;
      idx_q       <= '0;
      tmr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      tmr_q       <= tmr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    out_level_q <= out_level_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
  end

  assign empty        = !out_valid_q;
  assign line_level_o = out_level_q;
  assign slot_kind_o  = out_kind_q;
  assign last_slot_o  = out_last_q;

  `ASSERT_CLK(a_last_is_stop, (out_valid_q && out_last_q) |-> (out_kind_q == utf_pkg::KIND_STOP), "last slot is not a stop slot")
  `ASSERT_CLK(a_idx_range, (st_q == utf_pkg::ST_DATA) |-> (idx_q <= cur_q.last_idx), "data index past frame width")
  `ASSERT_CLK(a_start_after_rd, q_rd_o |=> (st_q == utf_pkg::ST_START), "frame read without starting it")
  `ASSERT_CLK(a_no_emit_on_timer, (tmr_q != '0) |-> !emit, "slot emitted before its period ran out")

endmodule

@@ hw/rtl/uart_tx_framer_top.sv @@
// ----------------------------------------------------------------------------
// uart_tx_framer_top
// Asynchronous serial transmit framer, one result request per bit slot.
// ----------------------------------------------------------------------------
// Usage: a byte request enters on push / full / data_byte_i and is taken at a
// clock edge with push high and full low. Each byte becomes one frame: a
// start slot, 5 to 8 data slots LSB first, an optional parity slot and one or
// two stop slots. Every slot leaves as one result request on empty / pop with
// line_level_o, slot_kind_o and last_slot_o; last_slot_o marks the final stop.
// The configuration channel (cfg_valid_i / cfg_ready_o, index and data) is
// always ready and is meant to be written while the framer is idle.
// When the serializer is idle, a taken byte passes through the frame queue,
// the serializer's frame register and the output register before its first
// slot shows on the result side. The serializer's slot timer paces the
// slots of each frame (7 to 12 of them) at the configured bit period. A
// two-entry frame queue lets the next bytes be taken while a frame is sent.
// Reset clears the queue, the serializer and the output register and restores
// 8 data bits, no parity, one stop bit, normal polarity and a period of 1667.
// When the receiver stalls, the current slot is held and the serializer waits;
// once the queue fills, full rises and byte requests back up.
// ----------------------------------------------------------------------------
module uart_tx_framer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte requests.
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  // Slot results.
  output logic        empty,
  input  logic        pop,
  output logic        line_level_o,
  output logic [1:0]  slot_kind_o,
  output logic        last_slot_o,
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Frame format and timing registers.
  utf_pkg::cfg_t   cfg_q, cfg_d;
  logic [15:0]     bit_period_q, bit_period_d;

  // Front end to queue, queue to serializer.
  logic            q_push;
  utf_pkg::frame_t q_wr_frame;
  logic            q_full;
  logic            q_rd;
  logic            q_valid;
  utf_pkg::frame_t q_rd_frame;

  // The register file never stalls a write.
  assign cfg_ready_o = 1'b1;

  // Register decode. Values are masked to the width of their register and
  // writes to unused indexes are dropped.
  always_comb begin
    cfg_d        = cfg_q;
    bit_period_d = bit_period_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        utf_pkg::REG_EXTRA_DATA_BITS: cfg_d.extra_data_bits = cfg_data_i[1:0];
        utf_pkg::REG_PARITY_MODE:     cfg_d.parity_mode     = cfg_data_i[1:0];
        utf_pkg::REG_TWO_STOP_BITS:   cfg_d.two_stop_bits   = cfg_data_i[0];
        utf_pkg::REG_INVERTED_LINE:   cfg_d.inverted_line   = cfg_data_i[0];
        utf_pkg::REG_BIT_PERIOD:      bit_period_d          = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.extra_data_bits <= utf_pkg::RST_EXTRA_DATA_BITS;
      cfg_q.parity_mode     <= utf_pkg::PAR_NONE;
      cfg_q.two_stop_bits   <= 1'b0;
      cfg_q.inverted_line   <= 1'b0;
      bit_period_q          <= utf_pkg::RST_BIT_PERIOD;
    end else begin
      cfg_q                 <= cfg_d;
      bit_period_q          <= bit_period_d;
    end
  end

  // The front end masks the byte, works out parity and packs a descriptor.
  utf_front u_front (
    .push        (push),
    .data_byte_i (data_byte_i),
    .cfg_i       (cfg_q),
    .q_full_i    (q_full),
    .full        (full),
    .q_push_o    (q_push),
    .q_frame_o   (q_wr_frame)
  );

  // Descriptor queue decouples byte intake from slot output.
  utf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (q_push),
    .wr_frame_i (q_wr_frame),
    .full_o     (q_full),
    .rd_i       (q_rd),
    .valid_o    (q_valid),
    .rd_frame_o (q_rd_frame)
  );

  // The serializer walks each frame slot by slot at the configured period.
  utf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .bit_period_i (bit_period_q),
    .q_valid_i    (q_valid),
    .q_frame_i    (q_rd_frame),
    .q_rd_o       (q_rd),
    .empty        (empty),
    .pop          (pop),
    .line_level_o (line_level_o),
    .slot_kind_o  (slot_kind_o),
    .last_slot_o  (last_slot_o)
  );

endmodule
